### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file ffha_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define FFHA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define FFHA_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
// No dependencies.
package ffha_pkg;

   localparam int HEAP_BYTES   = 65536;
   localparam int MAX_BLOCKS   = 32;
   localparam int HEADER_BYTES = 32;
   localparam int POS_W        = 8;   // cell position, up to 256 cells
   localparam int CNT_W        = 9;   // cell count, up to 256
   localparam logic [17:0] HDR18 = 18'(HEADER_BYTES);

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NO_HEAP = 3'd1,
      ST_ZERO    = 3'd2,
      ST_UNKNOWN = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef struct packed {
      logic [16:0] start;
      logic [16:0] size;
      logic        free;
   } entry_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_MARK,
      OP_SHIFT_UP,
      OP_SHIFT_DOWN,
      OP_SPLIT,
      OP_ABSORB,
      OP_APPEND
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [POS_W-1:0] pos;
      logic [CNT_W-1:0] cnt;
      logic             free;
      logic [17:0]      need;
      logic [16:0]      start;
      logic [15:0]      addr;
   } cell_cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_PICK,
      S_A_OPEN,
      S_A_SPLIT,
      S_A_GROW,
      S_R_MARK,
      S_R_LEFT,
      S_R_LDROP,
      S_R_RIGHT,
      S_R_RDROP,
      S_FIN
   } fsm_type;

endpackage

### hw/rtl/ffha_cell.sv
// One table cell: holds one heap block entry and exchanges it with its neighbors.
// Depends on ffha_pkg.
module ffha_cell #(
   parameter int IDX = 0
) (
   input  logic                  clock,
   input  ffha_pkg::cell_cmd_type cmd,
   input  ffha_pkg::entry_type   left,
   input  ffha_pkg::entry_type   right,
   output ffha_pkg::entry_type   ent,
   output logic                  fit,
   output logic                  spare_ok,
   output logic                  match,
   output logic                  live_free,
   output logic [15:0]           daddr
);
   import ffha_pkg::*;

   entry_type   ent_ff, ent_in;
   logic        live;
   logic [17:0] spare;
   logic [17:0] data18;

   always_comb begin
      ent_in = ent_ff;
      unique case (cmd.op)
         OP_NOP: ;
         OP_MARK:
            if (IDX == int'(cmd.pos)) ent_in.free = cmd.free;
         OP_SHIFT_UP:
            if (IDX > int'(cmd.pos)) ent_in = left;
         OP_SHIFT_DOWN:
            if (IDX >= int'(cmd.pos)) ent_in = right;
         OP_SPLIT: begin
            if (IDX == int'(cmd.pos)) begin
               ent_in.size = cmd.need[16:0];
               ent_in.free = 1'b0;
            end else if (IDX == int'(cmd.pos) + 1) begin
               ent_in.start = 17'({1'b0, left.start} + HDR18 + cmd.need);
               ent_in.size  = 17'({1'b0, left.size} - cmd.need - HDR18);
               ent_in.free  = 1'b1;
            end
         end
         OP_ABSORB:
            if (IDX == int'(cmd.pos))
               ent_in.size = 17'({1'b0, ent_ff.size} + HDR18 + {1'b0, right.size});
         OP_APPEND:
            if (IDX == int'(cmd.pos)) begin
               ent_in.start = cmd.start;
               ent_in.size  = cmd.need[16:0];
               ent_in.free  = 1'b0;
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign live      = IDX < int'(cmd.cnt);
   assign spare     = {1'b0, ent_ff.size} - cmd.need;
   assign data18    = {1'b0, ent_ff.start} + HDR18;
   assign fit       = live & ent_ff.free & ({1'b0, ent_ff.size} >= cmd.need);
   assign spare_ok  = spare >= (HDR18 + 18'd4);
   assign match     = live & (data18 == {2'b00, cmd.addr});
   assign live_free = live & ent_ff.free;
   assign daddr     = data18[15:0];
   assign ent       = ent_ff;

endmodule

### hw/rtl/first_fit_heap_allocator_top.sv
// First-fit heap allocator: a row of MAX_BLOCKS cells holds the address-ordered
// block table; a sequencer broadcasts one cell operation per cycle.
// Zero-size allocate and null release go straight to the result; an allocate
// takes a whole block, splits one or grows the heap; a release marks, then merges
// each free neighbour by add + shift. One transaction in work at a time; the next
// is accepted the cycle after its result is loaded, also while that result waits.
module first_fit_heap_allocator_top #(
   parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS
) (
   input  logic        clock,
   input  logic        reset,
   // configuration: heap_limit
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [16:0] request_size, [32:17] release_address, zero pad
   input  logic        req_tuser,   // command: 0 allocate, 1 release
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [15:0] data_address, [18:16] status, zero pad
);
   import ffha_pkg::*;

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(MAX_BLOCKS);

   fsm_type      state_ff, state_in;
   logic         cmd_ff, cmd_in;
   logic [17:0]  need_ff, need_in;
   logic [15:0]  addr_ff, addr_in;
   logic [IW-1:0] k_ff, k_in;
   status_type   status_ff, status_in;
   logic [15:0]  daddr_ff, daddr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [16:0]  top_ff, top_in;
   logic [16:0]  limit_ff;
   logic [MAX_BLOCKS-1:0] fit_ff, match_ff, spok_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [15:0]  rsp_addr_ff, rsp_addr_in;
   status_type   rsp_status_ff, rsp_status_in;

   cell_cmd_type cmd;
   entry_type    ent [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] fit_v, spok_v, match_v, free_v;
   logic [15:0]  cell_daddr [MAX_BLOCKS];

   // selection and arithmetic helpers
   logic [MAX_BLOCKS-1:0] pick_v, pick_oh;
   logic [IW-1:0] pick_idx;
   logic [15:0]  pick_addr;
   logic [17:0]  need_req;
   logic [17:0]  end_sum;
   logic [17:0]  limit_eff;
   logic [CW:0]  k_next;
   logic         accept;

   // cell row
   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      entry_type lft, rgt;
      if (i == 0) begin : g_l0
         assign lft = '0;
      end else begin : g_ln
         assign lft = ent[i-1];
      end
      if (i == MAX_BLOCKS - 1) begin : g_rl
         assign rgt = '0;
      end else begin : g_rn
         assign rgt = ent[i+1];
      end
      ffha_cell #(.IDX(i)) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .left      (lft),
         .right     (rgt),
         .ent       (ent[i]),
         .fit       (fit_v[i]),
         .spare_ok  (spok_v[i]),
         .match     (match_v[i]),
         .live_free (free_v[i]),
         .daddr     (cell_daddr[i])
      );
   end

   assign accept     = req_tvalid & req_tready;
   assign req_tready = (state_ff == S_IDLE) & ~reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_status_ff, rsp_addr_ff};

   // size rounded up to a multiple of 4 (garbage for zero, caught separately)
   assign need_req  = ((({1'b0, req_tdata[16:0]} - 18'd1) >> 2) << 2) + 18'd4;
   assign end_sum   = {1'b0, top_ff} + HDR18 + need_ff;
   assign limit_eff = ({1'b0, limit_ff} < 18'(HEAP_BYTES)) ? {1'b0, limit_ff}
                                                           : 18'(HEAP_BYTES);
   assign k_next    = {1'b0, CW'(k_ff)} + 1'b1;

   // first-set pick over the registered flag vector
   assign pick_v  = (cmd_ff == CMD_RELEASE) ? match_ff : fit_ff;
   assign pick_oh = pick_v & (~pick_v + 1'b1);
   always_comb begin
      pick_idx  = '0;
      pick_addr = '0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         if (pick_oh[i]) pick_idx = pick_idx | IW'(i);
         pick_addr = pick_addr | (cell_daddr[i] & {16{pick_oh[i]}});
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      need_in       = need_ff;
      addr_in       = addr_ff;
      k_in          = k_ff;
      status_in     = status_ff;
      daddr_in      = daddr_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;

      cmd       = '0;
      cmd.op    = OP_NOP;
      cmd.pos   = POS_W'(k_ff);
      cmd.cnt   = CNT_W'(count_ff);
      cmd.need  = need_ff;
      cmd.addr  = addr_ff;
      cmd.start = top_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in    = req_tuser;
               need_in   = need_req;
               addr_in   = req_tdata[32:17];
               daddr_in  = '0;
               status_in = ST_OK;
               if (req_tuser == CMD_ALLOC && req_tdata[16:0] == '0) begin
                  status_in = ST_ZERO;
                  state_in  = S_FIN;
               end else if (req_tuser == CMD_RELEASE && req_tdata[32:17] == '0) begin
                  state_in  = S_FIN;
               end else begin
                  state_in  = S_SEARCH;
               end
            end
         end
         S_SEARCH: state_in = S_PICK;
         S_PICK: begin
            k_in     = pick_idx;
            if (cmd_ff == CMD_RELEASE) begin
               if (|pick_v) state_in = S_R_MARK;
               else begin
                  status_in = ST_UNKNOWN;
                  state_in  = S_FIN;
               end
            end else if (|pick_v) begin
               daddr_in = pick_addr;
               if ((|(pick_oh & spok_ff)) && count_ff < CNT_FULL) begin
                  state_in = S_A_OPEN;
               end else begin
                  // hand out the whole block
                  cmd.op   = OP_MARK;
                  cmd.pos  = POS_W'(pick_idx);
                  cmd.free = 1'b0;
                  state_in = S_FIN;
               end
            end else begin
               state_in = S_A_GROW;
            end
         end
         S_A_OPEN: begin
            cmd.op   = OP_SHIFT_UP;
            count_in = count_ff + 1'b1;
            state_in = S_A_SPLIT;
         end
         S_A_SPLIT: begin
            cmd.op   = OP_SPLIT;
            state_in = S_FIN;
         end
         S_A_GROW: begin
            if (end_sum > limit_eff) status_in = ST_NO_HEAP;
            else if (count_ff >= CNT_FULL) status_in = ST_FULL;
            else begin
               cmd.op   = OP_APPEND;
               cmd.pos  = POS_W'(count_ff);
               count_in = count_ff + 1'b1;
               top_in   = end_sum[16:0];
               daddr_in = 16'({1'b0, top_ff} + HDR18);
            end
            state_in = S_FIN;
         end
         S_R_MARK: begin
            cmd.op   = OP_MARK;
            cmd.free = 1'b1;
            state_in = S_R_LEFT;
         end
         S_R_LEFT: begin
            if (k_ff != '0 && free_v[k_ff - 1'b1]) begin
               cmd.op   = OP_ABSORB;
               cmd.pos  = POS_W'(k_ff - 1'b1);
               state_in = S_R_LDROP;
            end else state_in = S_R_RIGHT;
         end
         S_R_LDROP: begin
            cmd.op   = OP_SHIFT_DOWN;
            count_in = count_ff - 1'b1;
            k_in     = k_ff - 1'b1;
            state_in = S_R_RIGHT;
         end
         S_R_RIGHT: begin
            if (k_next < {1'b0, count_ff} && free_v[k_next[IW-1:0]]) begin
               cmd.op   = OP_ABSORB;
               state_in = S_R_RDROP;
            end else state_in = S_FIN;
         end
         S_R_RDROP: begin
            cmd.op   = OP_SHIFT_DOWN;
            cmd.pos  = POS_W'(k_next);
            count_in = count_ff - 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = daddr_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         top_ff       <= '0;
         limit_ff     <= 17'd65536;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      need_ff       <= need_in;
      addr_ff       <= addr_in;
      k_ff          <= k_in;
      status_ff     <= status_in;
      daddr_ff      <= daddr_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      fit_ff        <= fit_v;
      match_ff      <= match_v;
      spok_ff       <= spok_v;
   end

endmodule

### hw/rtl/ffha_checker.sv
// Port-level checker for the allocator top, bound to it below.
// Depends on assert_macros.svh and ffha_pkg.
`include "assert_macros.svh"

module ffha_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   import ffha_pkg::*;

   `FFHA_ASSERT(a_status_range, clock, reset, rsp_tvalid |-> (rsp_tdata[18:16] <= ST_FULL), "bad status")
   `FFHA_ASSERT(a_fail_null, clock, reset, (rsp_tvalid && rsp_tdata[18:16] != ST_OK) |-> (rsp_tdata[15:0] == 16'd0), "failed transaction carries address")
   `FFHA_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "response dropped while stalled")
   `FFHA_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "response after reset")

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/first_fit_heap_allocator_checker.sv
// Checker for the first-fit heap allocator: watches the config, request and
// response channels, predicts each response and compares. Uses ffha_pkg.
module first_fit_heap_allocator_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   output int          error_count,
   output int          pending_count
);
   import ffha_pkg::*;

   typedef struct packed {
      logic [15:0] addr;
      status_type  status;
   } alloc_result_type;

   logic [16:0]   blk_start [MAX_BLOCKS];
   logic [16:0]   blk_size  [MAX_BLOCKS];
   logic          blk_free  [MAX_BLOCKS];
   int            blk_count;
   logic [16:0]   heap_top;
   logic [16:0]   heap_limit;
   alloc_result_type expected_q[$];

   assign pending_count = expected_q.size();

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic remove_block(input int k);
      for (int j = k; j + 1 < blk_count; j++) begin
         blk_start[j] = blk_start[j+1];
         blk_size[j]  = blk_size[j+1];
         blk_free[j]  = blk_free[j+1];
      end
      blk_count--;
   endtask

   task automatic insert_block(input int k);
      for (int j = blk_count; j > k; j--) begin
         blk_start[j] = blk_start[j-1];
         blk_size[j]  = blk_size[j-1];
         blk_free[j]  = blk_free[j-1];
      end
      blk_count++;
   endtask

   task automatic predict_alloc(input logic [16:0] raw, output alloc_result_type r);
      int unsigned need, spare, lim, end_pos;
      r.addr   = '0;
      r.status = ST_OK;
      if (raw == 0) begin
         r.status = ST_ZERO;
         return;
      end
      need = (((int'(raw) - 1) >> 2) << 2) + 4;
      for (int k = 0; k < blk_count; k++) begin
         if (blk_free[k] && blk_size[k] >= need) begin
            spare = blk_size[k] - need;
            if (spare >= HEADER_BYTES + 4 && blk_count < MAX_BLOCKS) begin
               insert_block(k + 1);
               blk_start[k+1] = 17'(blk_start[k] + HEADER_BYTES + need);
               blk_size[k+1]  = 17'(spare - HEADER_BYTES);
               blk_free[k+1]  = 1'b1;
               blk_size[k]    = 17'(need);
            end
            blk_free[k] = 1'b0;
            r.addr = 16'(blk_start[k] + HEADER_BYTES);
            return;
         end
      end
      lim     = (heap_limit < HEAP_BYTES) ? heap_limit : HEAP_BYTES;
      end_pos = heap_top + HEADER_BYTES + need;
      if (end_pos > lim) begin
         r.status = ST_NO_HEAP;
         return;
      end
      if (blk_count >= MAX_BLOCKS) begin
         r.status = ST_FULL;
         return;
      end
      blk_start[blk_count] = heap_top;
      blk_size[blk_count]  = 17'(need);
      blk_free[blk_count]  = 1'b0;
      blk_count++;
      heap_top = 17'(end_pos);
      r.addr   = 16'(blk_start[blk_count-1] + HEADER_BYTES);
   endtask

   task automatic predict_release(input logic [15:0] address, output alloc_result_type r);
      int k;
      r.addr   = '0;
      r.status = ST_OK;
      if (address == 0) return;
      for (k = 0; k < blk_count; k++)
         if (int'(blk_start[k]) + HEADER_BYTES == int'(address)) break;
      if (k >= blk_count) begin
         r.status = ST_UNKNOWN;
         return;
      end
      blk_free[k] = 1'b1;
      if (k > 0 && blk_free[k-1]) begin
         blk_size[k-1] = 17'(blk_size[k-1] + HEADER_BYTES + blk_size[k]);
         remove_block(k);
         k--;
      end
      if (k + 1 < blk_count && blk_free[k+1]) begin
         blk_size[k] = 17'(blk_size[k] + HEADER_BYTES + blk_size[k+1]);
         remove_block(k + 1);
      end
   endtask

   always @(posedge clock) begin
      alloc_result_type r, want;
      if (reset) begin
         blk_count  = 0;
         heap_top   = '0;
         heap_limit = 17'(65536);
         expected_q.delete();
      end else begin
         if (csr_wr_en) heap_limit = csr_wr_data;
         // responses come from older transactions, so pop before push
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected response", int'(rsp_tdata), 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata[15:0] !== want.addr)
                  report_mismatch("data_address", rsp_tdata[15:0], want.addr);
               if (rsp_tdata[18:16] !== want.status)
                  report_mismatch("status", rsp_tdata[18:16], want.status);
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == CMD_ALLOC) predict_alloc(req_tdata[16:0], r);
            else                        predict_release(req_tdata[32:17], r);
            expected_q.push_back(r);
         end
      end
   end

   initial error_count = 0;
endmodule

### tb/first_fit_heap_allocator_top_test.sv
// Top of the first-fit heap allocator test: clock, reset, stimulus and verdict.
// Depends on ffha_pkg, first_fit_heap_allocator_top and the checker module.
module first_fit_heap_allocator_top_test;
   import ffha_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [16:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // [16:0] request_size, [32:17] release_address
   logic        req_tuser = 1'b0; // command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [15:0] data_address, [18:16] status

   int          error_count, pending_count;
   int          in_flight = 0;     // transactions accepted minus responses taken
   int          idle_cycles = 0;
   logic        cmd_q[$];          // command of each transaction awaiting response
   logic [15:0] live_addr[$];      // allocated blocks the stimulus may release

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   first_fit_heap_allocator_top dut (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   first_fit_heap_allocator_checker checker_i (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .error_count, .pending_count
   );

   // Bookkeeping of outstanding transactions and live blocks; also the watchdog.
   always @(posedge clock) begin
      logic cmd;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            cmd_q.push_back(req_tuser);
            in_flight++;
         end
         if (rsp_tvalid && rsp_tready) begin
            cmd = cmd_q.pop_front();
            in_flight--;
            if (cmd == CMD_ALLOC && rsp_tdata[18:16] == ST_OK)
               live_addr.push_back(rsp_tdata[15:0]);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d transactions in flight", in_flight);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Response backpressure: mostly ready, short stalls, rare long ones, and
   // calm stretches with no stalls at all.
   int rsp_stall = 0;
   int rsp_calm  = 0;
   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (rsp_calm > 0) begin
         rsp_calm--;
         rsp_tready <= 1'b1;
      end else begin
         case ($urandom_range(0, 99)) inside
            [0:1]:   rsp_stall = $urandom_range(20, 60);
            [2:4]:   rsp_calm  = $urandom_range(50, 200);
            default: ;
         endcase
         rsp_tready <= ($urandom_range(0, 2) != 0);
      end
   end

   int fast_left = 0;   // items left in a gap-free stretch

   function automatic int pick_gap();
      if (fast_left > 0) begin
         fast_left--;
         return 0;
      end
      if ($urandom_range(0, 99) < 3) fast_left = $urandom_range(20, 80);
      case ($urandom_range(0, 19))
         0:       return $urandom_range(20, 50);
         1, 2, 3: return $urandom_range(1, 3);
         default: return 0;
      endcase
   endfunction

   // One request transaction; waits for its handshake.
   task automatic send(input logic cmd, input logic [16:0] size, input logic [15:0] addr);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'b0, addr, size};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drain all responses, let the block settle, then write heap_limit.
   task automatic set_limit(input logic [16:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic random_item();
      int          sel, idx;
      logic [16:0] size;
      logic [15:0] addr;
      size = 17'($urandom);
      addr = 16'($urandom);
      if ($urandom_range(0, 99) < 58) begin
         sel = $urandom_range(0, 99);
         if (sel < 4)       size = '0;
         else if (sel < 84) size = 17'($urandom_range(1, 512));
         else if (sel < 95) size = 17'($urandom_range(513, 8192));
         send(CMD_ALLOC, size, addr);
      end else begin
         sel = $urandom_range(0, 99);
         if (sel < 8) begin
            send(CMD_RELEASE, size, 16'd0);
         end else if (sel < 20 || live_addr.size() == 0) begin
            send(CMD_RELEASE, size, addr);         // mostly unknown addresses
         end else begin
            idx  = $urandom_range(0, live_addr.size() - 1);
            addr = live_addr[idx];
            // occasionally keep it listed so it gets released twice
            if ($urandom_range(0, 9) != 0) live_addr.delete(idx);
            send(CMD_RELEASE, size, addr);
         end
      end
   endtask

   task automatic random_phase(input int count);
      repeat (count) random_item();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero size, smallest, too large, null / unknown / double
      // release, reuse, split and growth
      send(CMD_ALLOC,   17'd0,       16'hFFFF);
      send(CMD_ALLOC,   17'd1,       16'h0);
      send(CMD_ALLOC,   17'd65536,   16'h0);
      send(CMD_ALLOC,   17'h1FFFF,   16'h0);
      send(CMD_RELEASE, 17'h1FFFF,   16'd0);
      send(CMD_RELEASE, 17'd0,       16'hFFFF);
      send(CMD_RELEASE, 17'd0,       16'd32);
      send(CMD_RELEASE, 17'd0,       16'd32);
      send(CMD_ALLOC,   17'd4,       16'h0);
      send(CMD_ALLOC,   17'd400,     16'h0);
      send(CMD_ALLOC,   17'd7,       16'h0);
      send(CMD_RELEASE, 17'd0,       16'd68);
      send(CMD_ALLOC,   17'd8,       16'h0);
      send(CMD_ALLOC,   17'd400,     16'h0);
      send(CMD_RELEASE, 17'd0,       16'd500);
      send(CMD_RELEASE, 17'd0,       16'd32);
      send(CMD_RELEASE, 17'd0,       16'd68);
      send(CMD_ALLOC,   17'd65000,   16'h0);
      send(CMD_ALLOC,   17'd3,       16'h0);

      // limit above the heap size: the heap size governs
      set_limit(17'h1FFFF);
      random_phase(350);
      // zero limit: every growth fails, only reuse succeeds
      set_limit(17'd0);
      random_phase(120);
      // small limit
      set_limit(17'd2000);
      random_phase(120);
      set_limit(17'd65536);
      random_phase(350);
      set_limit(17'($urandom_range(0, 65536)));
      random_phase(260);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0 && pending_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
